### hdl/assert_macros.svh
// Assertion macros for the frame unpacker RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication check.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

### hdl/pfu_pkg.sv
// Shared constants for the packed frame unpacker.
// No dependencies.
`default_nettype none

package pfu_pkg;

    localparam int MAX_FRAME = 2048;
    localparam int BYTE_W    = 8;
    localparam int FRAME_W   = 12;
    localparam int LEN_W     = 2 * BYTE_W;
    localparam int S_TDATA_W = ((BYTE_W + FRAME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = BYTE_W;
    localparam int M_TUSER_W = 2;

    localparam int M_TUSER_EMPTY = 0;
    localparam int M_TUSER_BAD   = 1;

endpackage

`default_nettype wire

### hdl/packed_frame_unpacker_core.sv
// Throughput: one word per cycle while m_axis_tready does not stall the result register.
// A stalled result word drops s_axis_tready in the same cycle if the input register is full.
// Reset: rst_n asynchronous active low; parser idles, packed tag clears to 0, both stages empty.
// Top level of the packed frame unpacker: byte parser with input and result registers.
// Depends on pfu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module packed_frame_unpacker_core
    import pfu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [BYTE_W-1:0]    cfg_data,       // packed_tag

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // data_byte[7:0], frame_length[19:8]
    input  wire logic                 s_axis_tuser,   // first

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,   // out_byte[7:0]
    output logic                      m_axis_tlast,   // packet_last
    output logic [M_TUSER_W-1:0]      m_axis_tuser    // empty_packet[0], bad_packing[1]
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_PASS,
        MODE_LEN_HI,
        MODE_LEN_LO,
        MODE_PAYLOAD,
        MODE_DISCARD
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [FRAME_W-1:0]  frame_left_reg, frame_left_next;
    logic [FRAME_W-1:0]  payload_left_reg, payload_left_next;
    logic [BYTE_W-1:0]   length_high_reg, length_high_next;
    logic [BYTE_W-1:0]   packed_tag_reg;

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_first_reg;
    logic [FRAME_W-1:0]  in_flen_reg;

    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;
    logic                out_empty_reg, out_empty_next;
    logic                out_bad_reg, out_bad_next;
    logic                emit;

    logic                advance;
    logic [FRAME_W-1:0]  flen_clamped;
    logic [FRAME_W-1:0]  flen_dec;
    logic [FRAME_W-1:0]  left_dec;
    logic [FRAME_W-1:0]  payload_dec;
    logic [LEN_W-1:0]    sub_len;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_bad_reg, out_empty_reg};

    always_comb
    begin
        if (in_flen_reg == '0)
            flen_clamped = FRAME_W'(1);
        else if (in_flen_reg > FRAME_W'(MAX_FRAME))
            flen_clamped = FRAME_W'(MAX_FRAME);
        else
            flen_clamped = in_flen_reg;
    end

    assign flen_dec    = flen_clamped - FRAME_W'(1);
    assign left_dec    = frame_left_reg - FRAME_W'(1);
    assign payload_dec = (payload_left_reg != '0) ? payload_left_reg - FRAME_W'(1)
                                                  : payload_left_reg;
    assign sub_len     = {length_high_reg, in_byte_reg};

    always_comb
    begin
        mode_next         = mode_reg;
        frame_left_next   = frame_left_reg;
        payload_left_next = payload_left_reg;
        length_high_next  = length_high_reg;
        emit              = 1'b0;
        out_byte_next     = '0;
        out_last_next     = 1'b0;
        out_empty_next    = 1'b0;
        out_bad_next      = 1'b0;

        if (in_first_reg)
        begin
            frame_left_next   = flen_dec;
            payload_left_next = '0;
            length_high_next  = '0;
            if (in_byte_reg == packed_tag_reg)
            begin
                mode_next = (flen_dec != '0) ? MODE_LEN_HI : MODE_IDLE;
            end
            else
            begin
                mode_next     = (flen_dec != '0) ? MODE_PASS : MODE_IDLE;
                emit          = 1'b1;
                out_byte_next = in_byte_reg;
                out_last_next = (flen_dec == '0);
            end
        end
        else if (mode_reg == MODE_IDLE || frame_left_reg == '0)
        begin
            mode_next = MODE_IDLE;
        end
        else
        begin
            frame_left_next = left_dec;
            unique case (mode_reg)
                MODE_PASS:
                begin
                    if (left_dec == '0)
                        mode_next = MODE_IDLE;
                    emit          = 1'b1;
                    out_byte_next = in_byte_reg;
                    out_last_next = (left_dec == '0);
                end
                MODE_LEN_HI:
                begin
                    length_high_next = in_byte_reg;
                    if (left_dec == '0)
                    begin
                        mode_next    = MODE_IDLE;
                        emit         = 1'b1;
                        out_bad_next = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_LEN_LO;
                    end
                end
                MODE_LEN_LO:
                begin
                    if (sub_len > LEN_W'(left_dec))
                    begin
                        mode_next    = (left_dec != '0) ? MODE_DISCARD : MODE_IDLE;
                        emit         = 1'b1;
                        out_bad_next = 1'b1;
                    end
                    else if (sub_len == '0)
                    begin
                        mode_next      = (left_dec != '0) ? MODE_LEN_HI : MODE_IDLE;
                        emit           = 1'b1;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b1;
                    end
                    else
                    begin
                        payload_left_next = sub_len[FRAME_W-1:0];
                        mode_next         = MODE_PAYLOAD;
                    end
                end
                MODE_PAYLOAD:
                begin
                    payload_left_next = payload_dec;
                    if (payload_dec == '0)
                        mode_next = (left_dec != '0) ? MODE_LEN_HI : MODE_IDLE;
                    emit          = 1'b1;
                    out_byte_next = in_byte_reg;
                    out_last_next = (payload_dec == '0);
                end
                MODE_DISCARD:
                begin
                    if (left_dec == '0)
                        mode_next = MODE_IDLE;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            frame_left_reg   <= '0;
            payload_left_reg <= '0;
            length_high_reg  <= '0;
            packed_tag_reg   <= '0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                packed_tag_reg <= cfg_data;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && emit;
                if (in_valid_reg)
                begin
                    mode_reg         <= mode_next;
                    frame_left_reg   <= frame_left_next;
                    payload_left_reg <= payload_left_next;
                    length_high_reg  <= length_high_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata[BYTE_W-1:0];
            in_first_reg <= s_axis_tuser;
            in_flen_reg  <= s_axis_tdata[BYTE_W+FRAME_W-1:BYTE_W];
        end
        if (advance && in_valid_reg)
        begin
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
            out_empty_reg <= out_empty_next;
            out_bad_reg   <= out_bad_next;
        end
    end

    `ASSERT_IMPL(a_bad_word_clean, out_valid_reg && out_bad_reg,
                 !out_last_reg && !out_empty_reg && out_byte_reg == '0)
    `ASSERT_IMPL(a_empty_word_last, out_valid_reg && out_empty_reg,
                 out_last_reg && out_byte_reg == '0)
    `ASSERT_IMPL(a_payload_nonzero, mode_reg == MODE_PAYLOAD, payload_left_reg != '0)
    `ASSERT_IMPL(a_payload_in_frame, mode_reg == MODE_PAYLOAD,
                 payload_left_reg <= frame_left_reg)
    `ASSERT_NEXT(a_stall_holds_state, in_valid_reg && !advance,
                 $stable(mode_reg) && $stable(frame_left_reg) && in_valid_reg)

endmodule

`default_nettype wire
